@@ rtl/irrc_pkg.sv @@
// Shared types and constants for the IPv4 range route classifier.
// No dependencies; every module in rtl/ imports this package.
package irrc_pkg;

  localparam int RuleDepth  = 16;  // default number of rule cells
  localparam int PortCount  = 16;  // ports at or above this count act as "no port"
  localparam int MaxResults = 16;  // forward results per classify transaction
  localparam int AddrW      = 32;
  localparam int PortW      = 4;
  localparam int IdxOutW    = 4;

  localparam logic OpAdd      = 1'b0;
  localparam logic OpClassify = 1'b1;

  typedef enum logic [1:0] {
    KindAdd  = 2'd0,
    KindFwd  = 2'd1,
    KindNone = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StAdded = 2'd0,
    StDup   = 2'd1,
    StFull  = 2'd2
  } add_status_e;

  typedef enum logic [1:0] {
    SIdle,
    SWalk,
    SAdd,
    SFinal
  } state_e;

  // what the cells compare while a token walks the chain
  typedef enum logic {
    ModeMatch,
    ModeDup
  } mode_e;

  typedef struct packed {
    logic [AddrW-1:0] dst_low;
    logic [AddrW-1:0] dst_high;
    logic [AddrW-1:0] src_low;
    logic [AddrW-1:0] src_high;
    logic [PortW-1:0] port;
    logic             port_valid;
    logic             stop;
  } rule_t;

  // walking key: classify uses w0 = dst, w1 = src; dup check uses all four
  typedef struct packed {
    logic [AddrW-1:0] w0;
    logic [AddrW-1:0] w1;
    logic [AddrW-1:0] w2;
    logic [AddrW-1:0] w3;
  } key_t;

  typedef struct packed {
    logic  load;
    logic  step;
    logic  flush;
    mode_e mode;
  } chain_ctl_t;

  // zero unless the cell holds the token
  typedef struct packed {
    logic             hit;
    logic [PortW-1:0] port;
    logic             port_valid;
    logic             stop;
  } cell_res_t;

  typedef struct packed {
    kind_e              kind;
    logic [PortW-1:0]   port;
    logic [IdxOutW-1:0] idx;
    add_status_e        status;
    logic               last;
  } result_t;

endpackage

@@ rtl/irrc_cell.sv @@
// One rule cell of the classifier chain: holds one rule and one key stage.
// Depends on irrc_pkg.
module irrc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  irrc_pkg::chain_ctl_t ctl_i,
  input  logic                 wr_en_i,
  input  irrc_pkg::rule_t      wr_rule_i,
  input  logic                 tok_i,
  input  irrc_pkg::key_t       key_i,
  output logic                 tok_o,
  output irrc_pkg::key_t       key_o,
  output irrc_pkg::cell_res_t  res_o
);
  import irrc_pkg::*;

  rule_t rule_q;
  logic  tok_q;
  key_t  key_q;
  logic  match;

  // zero at either end of a range is a wildcard
  function automatic logic in_range(logic [AddrW-1:0] addr, logic [AddrW-1:0] lo,
                                    logic [AddrW-1:0] hi);
    return (lo == '0) || (hi == '0) || ((addr >= lo) && (addr <= hi));
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rule_q <= wr_rule_i;
    end
    if (ctl_i.load || ctl_i.step) begin
      key_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (ctl_i.flush) begin
      tok_q <= 1'b0;
    end else if (ctl_i.load || ctl_i.step) begin
      tok_q <= tok_i;
    end
  end

  always_comb begin
    unique case (ctl_i.mode)
      ModeMatch: match = in_range(key_q.w0, rule_q.dst_low, rule_q.dst_high) &&
                         in_range(key_q.w1, rule_q.src_low, rule_q.src_high);
      ModeDup:   match = (key_q.w0 == rule_q.dst_low) && (key_q.w1 == rule_q.dst_high) &&
                         (key_q.w2 == rule_q.src_low) && (key_q.w3 == rule_q.src_high);
      default:   match = 1'b0;
    endcase
  end

  assign res_o.hit        = tok_q && match;
  assign res_o.port       = tok_q ? rule_q.port : '0;
  assign res_o.port_valid = tok_q && rule_q.port_valid;
  assign res_o.stop       = tok_q && rule_q.stop;

  assign tok_o = tok_q;
  assign key_o = key_q;

endmodule

@@ rtl/irrc_ctrl.sv @@
// Walk sequencer, rule count, config register and output staging.
// Depends on irrc_pkg; drives the cell chain built in the top level.
module irrc_ctrl #(
  parameter int RULE_DEPTH = irrc_pkg::RuleDepth,
  localparam int CntW = $clog2(RULE_DEPTH + 1),
  localparam int IdxW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [irrc_pkg::AddrW-1:0]   dst_addr_i,
  input  logic [irrc_pkg::AddrW-1:0]   src_addr_i,
  input  logic                         header_ok_i,
  input  irrc_pkg::rule_t              rule_i,
  input  logic                         replace_mode_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output irrc_pkg::result_t            out_o,
  output irrc_pkg::chain_ctl_t         ctl_o,
  output irrc_pkg::key_t               key_o,
  output logic                         wr_en_o,
  output logic [IdxW-1:0]              wr_idx_o,
  output irrc_pkg::rule_t              wr_rule_o,
  input  irrc_pkg::cell_res_t          res_i
);
  import irrc_pkg::*;

  localparam int NW = $clog2(MaxResults + 1);

  state_e           state_q, state_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]    n_q, n_d;
  mode_e            mode_q, mode_d;
  rule_t            rule_q, rule_d;
  logic             pend_vld_q, pend_vld_d;
  result_t          pend_q, pend_d;
  logic             out_vld_q, out_vld_d;
  result_t          out_q, out_d;
  logic             open_q;

  logic accept, slot_free, walk_end, port_ok, emit, stall, full, start_walk, ends_here;

  assign accept     = in_valid_i && (state_q == SIdle);
  assign slot_free  = !out_vld_q || out_ready_i;
  assign walk_end   = (pos_q == cnt_q);
  assign port_ok    = int'(res_i.port) < PortCount;
  assign emit       = (mode_q == ModeMatch) && res_i.hit && res_i.port_valid && port_ok &&
                      (n_q < NW'(MaxResults));
  assign stall      = emit && pend_vld_q && !slot_free;
  assign full       = (cnt_q == CntW'(RULE_DEPTH));
  assign start_walk = (op_i == OpClassify) ? (open_q && header_ok_i) : replace_mode_i;
  assign ends_here  = res_i.hit && ((mode_q == ModeDup) || res_i.stop);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (start_walk) state_d = SWalk;
          else if (op_i == OpClassify) state_d = SFinal;
          else state_d = SAdd;
        end
      end
      SWalk: begin
        if (walk_end) begin
          state_d = (mode_q == ModeDup) ? SAdd : SFinal;
        end else if (!stall && ends_here) begin
          state_d = SFinal;
        end
      end
      SAdd: state_d = SFinal;
      SFinal: begin
        if (slot_free) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    mode_d     = mode_q;
    rule_d     = rule_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_d      = out_q;
    in_ready_o = 1'b0;
    wr_en_o    = 1'b0;
    ctl_o      = '{load: 1'b0, step: 1'b0, flush: 1'b0, mode: mode_q};
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (accept) begin
          mode_d     = (op_i == OpClassify) ? ModeMatch : ModeDup;
          rule_d     = rule_i;
          pos_d      = '0;
          n_d        = '0;
          pend_vld_d = 1'b0;
          ctl_o.load = start_walk;
        end
      end
      SWalk: begin
        if (walk_end) begin
          ctl_o.flush = 1'b1;
        end else if (!stall) begin
          ctl_o.step = 1'b1;
          pos_d      = pos_q + 1'b1;
          if (emit) begin
            pend_d     = '{kind: KindFwd, port: res_i.port, idx: IdxOutW'(pos_q),
                           status: StAdded, last: 1'b0};
            pend_vld_d = 1'b1;
            n_d        = n_q + 1'b1;
            if (pend_vld_q) begin
              out_d     = pend_q;
              out_vld_d = 1'b1;
            end
          end
          if (mode_q == ModeDup && res_i.hit) begin
            pend_d     = '{kind: KindAdd, port: '0, idx: IdxOutW'(pos_q),
                           status: StDup, last: 1'b0};
            pend_vld_d = 1'b1;
          end
          if (ends_here) ctl_o.flush = 1'b1;
        end
      end
      SAdd: begin
        pend_vld_d = 1'b1;
        if (full) begin
          pend_d = '{kind: KindAdd, port: '0, idx: '0, status: StFull, last: 1'b0};
        end else begin
          wr_en_o = 1'b1;
          pend_d  = '{kind: KindAdd, port: '0, idx: IdxOutW'(cnt_q),
                      status: StAdded, last: 1'b0};
          cnt_d   = cnt_q + 1'b1;
        end
      end
      SFinal: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d = '{kind: KindNone, port: '0, idx: '0, status: StAdded, last: 1'b1};
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (op_i == OpClassify) begin
      key_o = '{w0: dst_addr_i, w1: src_addr_i, w2: '0, w3: '0};
    end else begin
      key_o = '{w0: rule_i.dst_low, w1: rule_i.dst_high,
                w2: rule_i.src_low, w3: rule_i.src_high};
    end
  end

  assign wr_idx_o    = cnt_q[IdxW-1:0];
  assign wr_rule_o   = rule_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      pos_q      <= '0;
      cnt_q      <= '0;
      n_q        <= '0;
      mode_q     <= ModeMatch;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      open_q     <= 1'b1;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      n_q        <= n_d;
      mode_q     <= mode_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) open_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rule_q <= rule_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule

@@ rtl/ip_range_route_classifier.sv @@
// Add: in replace mode a duplicate scan of the held rules comes before the output register;
// classify walks the held rules when open with a good header, ending early on a stop hit.
// Throughput: one transaction at a time; the token walk steps one rule cell per cycle,
// so the chain of rule cells sets the rate, and output backpressure stalls the walk.
// Reset (async, active low): rule count zero, router open, output empty; rule
// cells are not cleared and are only read below the rule count.
module ip_range_route_classifier #(
  parameter int RULE_DEPTH = irrc_pkg::RuleDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // router_open register
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  // input transaction
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [irrc_pkg::AddrW-1:0] dst_addr_i,
  input  logic [irrc_pkg::AddrW-1:0] src_addr_i,
  input  logic                       header_ok_i,
  input  logic [irrc_pkg::AddrW-1:0] rule_dst_low_i,
  input  logic [irrc_pkg::AddrW-1:0] rule_dst_high_i,
  input  logic [irrc_pkg::AddrW-1:0] rule_src_low_i,
  input  logic [irrc_pkg::AddrW-1:0] rule_src_high_i,
  input  logic [irrc_pkg::PortW-1:0] rule_port_i,
  input  logic                       rule_port_valid_i,
  input  logic                       rule_stop_i,
  input  logic                       replace_mode_i,
  // result transaction
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [irrc_pkg::PortW-1:0] port_o,
  output logic [3:0]                 rule_index_o,
  output logic [1:0]                 add_status_o,
  output logic                       last_o
);
  import irrc_pkg::*;

  localparam int IdxW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

  rule_t            rule_in;
  rule_t            wr_rule;
  chain_ctl_t       ctl;
  key_t             load_key;
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  cell_res_t        res_or;
  result_t          out_res;

  // token and key travel from cell k to cell k+1 on each walk step;
  // stage 0 is the load point fed by the sequencer
  logic             tok [RULE_DEPTH+1];
  key_t             key [RULE_DEPTH+1];
  cell_res_t        res [RULE_DEPTH];

  assign rule_in = '{dst_low: rule_dst_low_i, dst_high: rule_dst_high_i,
                     src_low: rule_src_low_i, src_high: rule_src_high_i,
                     port: rule_port_i, port_valid: rule_port_valid_i,
                     stop: rule_stop_i};

  irrc_ctrl #(
    .RULE_DEPTH(RULE_DEPTH)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .dst_addr_i,
    .src_addr_i,
    .header_ok_i,
    .rule_i        (rule_in),
    .replace_mode_i,
    .out_valid_o,
    .out_ready_i,
    .out_o         (out_res),
    .ctl_o         (ctl),
    .key_o         (load_key),
    .wr_en_o       (wr_en),
    .wr_idx_o      (wr_idx),
    .wr_rule_o     (wr_rule),
    .res_i         (res_or)
  );

  assign tok[0] = ctl.load;
  assign key[0] = load_key;

  for (genvar k = 0; k < RULE_DEPTH; k++) begin : g_cell
    irrc_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i     (ctl),
      .wr_en_i   (wr_en && (wr_idx == IdxW'(k))),
      .wr_rule_i (wr_rule),
      .tok_i     (tok[k]),
      .key_i     (key[k]),
      .tok_o     (tok[k+1]),
      .key_o     (key[k+1]),
      .res_o     (res[k])
    );
  end

  // only the token holder drives nonzero, so an OR picks its verdict
  always_comb begin
    res_or = '0;
    for (int k = 0; k < RULE_DEPTH; k++) begin
      res_or = cell_res_t'(res_or | res[k]);
    end
  end

  assign kind_o       = out_res.kind;
  assign port_o       = out_res.port;
  assign rule_index_o = out_res.idx;
  assign add_status_o = out_res.status;
  assign last_o       = out_res.last;

endmodule
